// ===== hdl/alarm_offer_repeat_expire_top_assert.svh =====
// Assertion macros for the alarm offer/repeat/expire block.
`ifndef ALARM_OFFER_REPEAT_EXPIRE_TOP_ASSERT_SVH
`define ALARM_OFFER_REPEAT_EXPIRE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Implication checked on every rising edge once reset is released
`define AORE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aore: implication failed");
// Next-cycle implication checked once reset is released
`define AORE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aore: next-cycle implication failed");
`else
`define AORE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define AORE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/aore_pkg.sv =====
// Shared types and constants for the alarm offer/repeat/expire block.
package aore_pkg;

    localparam int unsigned GRACE_W  = 17;
    localparam int unsigned RINGS_W  = 6;
    localparam int unsigned PERIOD_W = 12;
    localparam int unsigned WAIT_W   = 17;
    localparam int unsigned ACTION_W = 4;
    localparam int unsigned CODE_W   = 2;
    localparam int unsigned CFG_ADDR_W = 8;
    localparam int unsigned CFG_DATA_W = 17;

    // result packing: action, wait_seconds, still_pending, padded to bytes
    localparam int unsigned RES_BITS = ACTION_W + WAIT_W + 1;
    localparam int unsigned OUT_W    = ((RES_BITS + 7) / 8) * 8;

    localparam logic [WAIT_W-1:0] WAIT_CAP = 17'd86400;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_GRACE  = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RINGS  = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_BUSY   = 8'd3;

    // answer codes
    localparam logic [CODE_W-1:0] ANS_NONE    = 2'd0;
    localparam logic [CODE_W-1:0] ANS_START   = 2'd1;
    localparam logic [CODE_W-1:0] ANS_DISMISS = 2'd2;

    // item kinds on s_tuser
    localparam logic MODE_ARM     = 1'b0;
    localparam logic MODE_SERVICE = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ARMED     = 4'd0,
        ACT_STARTED   = 4'd1,
        ACT_DISMISSED = 4'd2,
        ACT_EXPIRED   = 4'd3,
        ACT_QUIET     = 4'd4,
        ACT_RERANG    = 4'd5,
        ACT_WAITING   = 4'd6,
        ACT_MISSED    = 4'd7,
        ACT_DEFERRED  = 4'd8,
        ACT_RANG      = 4'd9,
        ACT_REFUSED   = 4'd10,
        ACT_IDLE      = 4'd11
    } action_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] busy_retry_s;
        logic [PERIOD_W-1:0] repeat_s;
        logic [RINGS_W-1:0]  max_rings;
        logic [GRACE_W-1:0]  grace_window_s;
    } cfg_t;

    // packed so that action lands in the lowest bits
    typedef struct packed {
        logic              still_pending;
        logic [WAIT_W-1:0] wait_seconds;
        action_t           action;
    } result_t;

endpackage

// ===== hdl/aore_cfg_regs.sv =====
// Configuration register file for the alarm block.
module aore_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [aore_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [aore_pkg::CFG_DATA_W-1:0] cfg_data,
    output aore_pkg::cfg_t                 cfg
);
    import aore_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // writes are always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_addr)
                CFG_GRACE:  cfg_next.grace_window_s = cfg_data[GRACE_W-1:0];
                CFG_RINGS:  cfg_next.max_rings      = cfg_data[RINGS_W-1:0];
                CFG_REPEAT: cfg_next.repeat_s       = cfg_data[PERIOD_W-1:0];
                CFG_BUSY:   cfg_next.busy_retry_s   = cfg_data[PERIOD_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grace_window_s <= 17'd1800;
            cfg_reg.max_rings      <= 6'd4;
            cfg_reg.repeat_s       <= 12'd20;
            cfg_reg.busy_retry_s   <= 12'd30;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/aore_decide.sv =====
// Decision logic: one item against the pending alarm state.
module aore_decide #(
    parameter int unsigned TIME_BITS = 33
) (
    input  logic                        mode,
    input  logic [TIME_BITS-1:0]        now,
    input  logic [TIME_BITS-1:0]        occurrence_time,
    input  logic [aore_pkg::CODE_W-1:0] answer_code,
    input  logic                        answer_is_for_pending,
    input  logic                        routine_active,
    input  logic                        start_accepted,
    input  aore_pkg::cfg_t              cfg,
    // current state
    input  logic                        pending_valid,
    input  logic [TIME_BITS-1:0]        pending_time,
    input  logic                        offer_shown,
    input  logic [aore_pkg::RINGS_W-1:0] ring_count,
    input  logic [TIME_BITS-1:0]        last_ring_time,
    // state after this item
    output logic                        pending_valid_nx,
    output logic [TIME_BITS-1:0]        pending_time_nx,
    output logic                        offer_shown_nx,
    output logic [aore_pkg::RINGS_W-1:0] ring_count_nx,
    output logic [TIME_BITS-1:0]        last_ring_time_nx,
    output aore_pkg::result_t           result
);
    import aore_pkg::*;

    // a + b, saturated at the wait cap
    function automatic logic [WAIT_W-1:0] sat_add(input logic [WAIT_W-1:0] a,
                                                  input logic [TIME_BITS-1:0] b);
        logic [WAIT_W:0] sum;
        logic            big;
        begin
            big = |b[TIME_BITS-1:WAIT_W];
            sum = {1'b0, a} + {1'b0, b[WAIT_W-1:0]};
            if (big || sum >= {1'b0, WAIT_CAP}) return WAIT_CAP;
            return sum[WAIT_W-1:0];
        end
    endfunction

    function automatic logic [WAIT_W-1:0] cap(input logic [WAIT_W-1:0] v);
        begin
            return (v > WAIT_CAP) ? WAIT_CAP : v;
        end
    endfunction

    logic                 late;
    logic [TIME_BITS-1:0] late_by;
    logic [TIME_BITS-1:0] early_by;
    logic                 past_grace;
    logic                 answered;
    logic                 rang_before;
    logic [TIME_BITS-1:0] since;
    logic [TIME_BITS-1:0] ahead;
    logic [TIME_BITS-1:0] grace_ext;
    logic [TIME_BITS-1:0] repeat_ext;
    logic [WAIT_W-1:0]    repeat_w;
    logic [WAIT_W-1:0]    busy_w;

    // time differences and compares
    assign grace_ext   = {{(TIME_BITS-GRACE_W){1'b0}}, cfg.grace_window_s};
    assign repeat_ext  = {{(TIME_BITS-PERIOD_W){1'b0}}, cfg.repeat_s};
    assign repeat_w    = {{(WAIT_W-PERIOD_W){1'b0}}, cfg.repeat_s};
    assign busy_w      = {{(WAIT_W-PERIOD_W){1'b0}}, cfg.busy_retry_s};
    assign late        = now > pending_time;
    assign late_by     = now - pending_time;
    assign early_by    = pending_time - now;
    assign past_grace  = late && (late_by > grace_ext);
    assign answered    = offer_shown && answer_is_for_pending &&
                         (answer_code == ANS_START || answer_code == ANS_DISMISS);
    assign rang_before = now >= last_ring_time;
    assign since       = now - last_ring_time;
    assign ahead       = last_ring_time - now;

    // priority chain: arming first, then the service pass
    always_comb begin
        pending_valid_nx  = pending_valid;
        pending_time_nx   = pending_time;
        offer_shown_nx    = offer_shown;
        ring_count_nx     = ring_count;
        last_ring_time_nx = last_ring_time;
        result.action       = ACT_IDLE;
        result.wait_seconds = '0;

        if (mode == MODE_ARM) begin
            pending_valid_nx  = 1'b1;
            pending_time_nx   = occurrence_time;
            offer_shown_nx    = 1'b0;
            ring_count_nx     = '0;
            last_ring_time_nx = '0;
            result.action     = ACT_ARMED;
        end else if (!pending_valid) begin
            result.action = ACT_IDLE;
        end else if (answered || (offer_shown && past_grace) ||
                     (!offer_shown && past_grace)) begin
            // occurrence closes: answer, expiry or missed
            pending_valid_nx  = 1'b0;
            pending_time_nx   = '0;
            offer_shown_nx    = 1'b0;
            ring_count_nx     = '0;
            last_ring_time_nx = '0;
            result.wait_seconds = 17'd1;
            if (answered) begin
                result.action = (answer_code == ANS_START) ? ACT_STARTED : ACT_DISMISSED;
            end else if (offer_shown) begin
                result.action = ACT_EXPIRED;
            end else begin
                result.action = ACT_MISSED;
            end
        end else if (offer_shown) begin
            if (ring_count >= cfg.max_rings) begin
                result.action = ACT_QUIET;
                result.wait_seconds = late ?
                    cap(cfg.grace_window_s - late_by[WAIT_W-1:0]) :
                    sat_add(cfg.grace_window_s, early_by);
            end else if (rang_before && since >= repeat_ext) begin
                result.action       = ACT_RERANG;
                ring_count_nx       = ring_count + 6'd1;
                last_ring_time_nx   = now;
                result.wait_seconds = repeat_w;
            end else if (rang_before) begin
                result.action       = ACT_WAITING;
                result.wait_seconds = repeat_w - {{(WAIT_W-PERIOD_W){1'b0}},
                                                  since[PERIOD_W-1:0]};
            end else begin
                result.action       = ACT_WAITING;
                result.wait_seconds = sat_add(repeat_w, ahead);
            end
        end else if (routine_active) begin
            result.action       = ACT_DEFERRED;
            result.wait_seconds = busy_w;
        end else begin
            // ring and raise the offer, or drop the alarm if the start is refused
            result.wait_seconds = repeat_w;
            if (start_accepted) begin
                result.action     = ACT_RANG;
                offer_shown_nx    = 1'b1;
                ring_count_nx     = ring_count + 6'd1;
                last_ring_time_nx = now;
            end else begin
                result.action     = ACT_REFUSED;
                pending_valid_nx  = 1'b0;
                pending_time_nx   = '0;
                offer_shown_nx    = 1'b0;
                ring_count_nx     = '0;
                last_ring_time_nx = '0;
            end
        end

        result.still_pending = pending_valid_nx;
    end

endmodule

// ===== hdl/alarm_offer_repeat_expire_top.sv =====
// Top level of the alarm offer/repeat/expire block.
//
//  channel | direction | contents
//  s_      | in        | tuser: mode; tdata: now, occurrence_time, answer_code,
//          |           |   answer_is_for_pending, routine_active, start_accepted
//  m_      | out       | tdata: action, wait_seconds, still_pending
//  cfg_    | in        | addr: register index, data: value (always ready)
//
// One request per cycle while the result is taken: an input register feeds
// the decision logic, whose result and new alarm state are written together
// into the result register.
// A held result stalls the input register; a new request is still taken in
// the cycle that the stalled one advances.
// aresetn (synchronous) clears the pending alarm and loads register defaults.
module alarm_offer_repeat_expire_top #(
    parameter int unsigned TIME_BITS = 33
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input requests
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata from bit 0: now, occurrence_time, answer_code,
    // answer_is_for_pending, routine_active, start_accepted, zero fill
    input  logic [((2*TIME_BITS+5+7)/8)*8-1:0] s_tdata,
    // tuser: mode
    input  logic                            s_tuser,
    // results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata from bit 0: action, wait_seconds, still_pending, zero fill
    output logic [aore_pkg::OUT_W-1:0]      m_tdata,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [aore_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [aore_pkg::CFG_DATA_W-1:0] cfg_data
);
    import aore_pkg::*;

    localparam int unsigned IN_W = ((2*TIME_BITS + 5 + 7) / 8) * 8;
    localparam int unsigned OCC_LO  = TIME_BITS;
    localparam int unsigned CODE_LO = 2 * TIME_BITS;
    localparam int unsigned FOR_B   = CODE_LO + CODE_W;
    localparam int unsigned BUSY_B  = FOR_B + 1;
    localparam int unsigned ACC_B   = BUSY_B + 1;

    cfg_t cfg;

    logic            in_valid_reg;
    logic            in_valid_next;
    logic [IN_W-1:0] in_data_reg;
    logic            in_mode_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    result_t         out_data_reg;
    logic            advance;

    logic                 pending_valid_reg;
    logic [TIME_BITS-1:0] pending_time_reg;
    logic                 offer_shown_reg;
    logic [RINGS_W-1:0]   ring_count_reg;
    logic [TIME_BITS-1:0] last_ring_time_reg;

    logic                 pending_valid_next;
    logic [TIME_BITS-1:0] pending_time_next;
    logic                 offer_shown_next;
    logic [RINGS_W-1:0]   ring_count_next;
    logic [TIME_BITS-1:0] last_ring_time_next;
    result_t              result;

    aore_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    aore_decide #(
        .TIME_BITS (TIME_BITS)
    ) u_decide (
        .mode                  (in_mode_reg),
        .now                   (in_data_reg[TIME_BITS-1:0]),
        .occurrence_time       (in_data_reg[OCC_LO +: TIME_BITS]),
        .answer_code           (in_data_reg[CODE_LO +: CODE_W]),
        .answer_is_for_pending (in_data_reg[FOR_B]),
        .routine_active        (in_data_reg[BUSY_B]),
        .start_accepted        (in_data_reg[ACC_B]),
        .cfg                   (cfg),
        .pending_valid         (pending_valid_reg),
        .pending_time          (pending_time_reg),
        .offer_shown           (offer_shown_reg),
        .ring_count            (ring_count_reg),
        .last_ring_time        (last_ring_time_reg),
        .pending_valid_nx      (pending_valid_next),
        .pending_time_nx       (pending_time_next),
        .offer_shown_nx        (offer_shown_next),
        .ring_count_nx         (ring_count_next),
        .last_ring_time_nx     (last_ring_time_next),
        .result                (result)
    );

    // handshake and stage control
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W-RES_BITS){1'b0}}, out_data_reg};

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            pending_valid_reg <= 1'b0;
            offer_shown_reg   <= 1'b0;
            ring_count_reg    <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                pending_valid_reg <= pending_valid_next;
                offer_shown_reg   <= offer_shown_next;
                ring_count_reg    <= ring_count_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_mode_reg <= s_tuser;
        end
        if (advance) begin
            out_data_reg       <= result;
            pending_time_reg   <= pending_time_next;
            last_ring_time_reg <= last_ring_time_next;
        end
    end

`include "alarm_offer_repeat_expire_top_assert.svh"

    `AORE_ASSERT_IMP(a_offer_needs_pending, aclk, aresetn, offer_shown_reg, pending_valid_reg)
    `AORE_ASSERT_IMP(a_idle_ring_clear, aclk, aresetn, !pending_valid_reg, ring_count_reg == '0)
    `AORE_ASSERT_NEXT(a_result_tracks_state, aclk, aresetn, advance, out_data_reg.still_pending == pending_valid_reg)
    `AORE_ASSERT_IMP(a_idle_result, aclk, aresetn, out_valid_reg && out_data_reg.action == ACT_IDLE, out_data_reg.wait_seconds == '0 && !out_data_reg.still_pending)

endmodule

// ===== test/tb_alarm_offer_repeat_expire_top.sv =====
// Testbench for the alarm offer/repeat/expire block: directed and random requests, scored on the fly.
`timescale 1ns / 1ps

module tb_alarm_offer_repeat_expire_top;
    import aore_pkg::*;

    localparam int unsigned TB_TIME_BITS = 33;
    localparam int unsigned IN_W         = ((2*TB_TIME_BITS+5+7)/8)*8;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 4;

    // spare answer code, read as no answer
    localparam logic [CODE_W-1:0] ANS_SPARE = 2'd3;

    typedef logic [TB_TIME_BITS-1:0] stamp_t;

    // Alarm predictor and store of expected results
    class alarm_scoreboard;
        longint unsigned grace;
        longint unsigned ring_cap;
        longint unsigned repeat_iv;
        longint unsigned retry_iv;

        bit              armed;
        longint unsigned moment;
        bit              offered;
        bit [5:0]        tones;
        longint unsigned last_tone;

        result_t due_q[$];
        int      errors;

        function new();
            grace     = 1800;
            ring_cap  = 4;
            repeat_iv = 20;
            retry_iv  = 30;
            errors    = 0;
            clear_alarm();
        endfunction

        function void clear_alarm();
            armed     = 1'b0;
            moment    = 0;
            offered   = 1'b0;
            tones     = '0;
            last_tone = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_GRACE:  grace     = val[GRACE_W-1:0];
                CFG_RINGS:  ring_cap  = val[RINGS_W-1:0];
                CFG_REPEAT: repeat_iv = val[PERIOD_W-1:0];
                CFG_BUSY:   retry_iv  = val[PERIOD_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned clip(longint unsigned v);
            return (v > WAIT_CAP) ? longint'(WAIT_CAP) : v;
        endfunction

        // a + b held at the wait cap
        function longint unsigned sum_clip(longint unsigned a, longint unsigned b);
            if (a >= WAIT_CAP || b >= WAIT_CAP - a) return WAIT_CAP;
            return a + b;
        endfunction

        function void ring(longint unsigned at);
            tones     = tones + 6'd1;
            last_tone = at;
        endfunction

        // Work out the result of one accepted request
        function void note_request(logic mode, stamp_t now_t, stamp_t occ, logic [1:0] code,
                                   logic for_p, logic busy_f, logic acc);
            action_t         act;
            longint unsigned wt;
            longint unsigned t;
            bit              late;
            bit              past;
            longint unsigned late_by;
            longint unsigned early_by;
            longint unsigned since;
            result_t         r;

            wt = 0;
            t  = now_t;
            if (mode == MODE_ARM) begin
                clear_alarm();
                armed  = 1'b1;
                moment = occ;
                act    = ACT_ARMED;
            end else if (!armed) begin
                act = ACT_IDLE;
            end else begin
                late     = t > moment;
                late_by  = late ? t - moment : 0;
                early_by = late ? 0 : moment - t;
                past     = late && late_by > grace;
                if (offered && for_p && (code == ANS_START || code == ANS_DISMISS)) begin
                    act = (code == ANS_START) ? ACT_STARTED : ACT_DISMISSED;
                    clear_alarm();
                    wt = 1;
                end else if (offered) begin
                    if (past) begin
                        act = ACT_EXPIRED;
                        clear_alarm();
                        wt = 1;
                    end else if (tones >= ring_cap) begin
                        act = ACT_QUIET;
                        wt  = late ? clip(grace - late_by) : sum_clip(grace, early_by);
                    end else if (t >= last_tone) begin
                        since = t - last_tone;
                        if (since >= repeat_iv) begin
                            act = ACT_RERANG;
                            ring(t);
                            wt = clip(repeat_iv);
                        end else begin
                            act = ACT_WAITING;
                            wt  = clip(repeat_iv - since);
                        end
                    end else begin
                        act = ACT_WAITING;
                        wt  = sum_clip(repeat_iv, last_tone - t);
                    end
                end else if (past) begin
                    act = ACT_MISSED;
                    clear_alarm();
                    wt = 1;
                end else if (busy_f) begin
                    act = ACT_DEFERRED;
                    wt  = clip(retry_iv);
                end else begin
                    ring(t);
                    if (acc) begin
                        act     = ACT_RANG;
                        offered = 1'b1;
                    end else begin
                        act = ACT_REFUSED;
                        clear_alarm();
                    end
                    wt = clip(repeat_iv);
                end
            end
            r.action        = act;
            r.wait_seconds  = wt[WAIT_W-1:0];
            r.still_pending = armed;
            due_q.push_back(r);
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(logic [OUT_W-1:0] d);
            result_t got;
            result_t want;

            got = result_t'(d[RES_BITS-1:0]);
            if (due_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with nothing expected: action %0d wait %0d pending %0b",
                             $realtime, got.action, got.wait_seconds, got.still_pending);
                return;
            end
            want = due_q.pop_front();
            if (got.action !== want.action || got.wait_seconds !== want.wait_seconds ||
                got.still_pending !== want.still_pending) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch: expected action %0d wait %0d pending %0b, got %0d %0d %0b",
                             $realtime, want.action, want.wait_seconds, want.still_pending,
                             got.action, got.wait_seconds, got.still_pending);
            end
        endfunction
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    alarm_scoreboard sb = new();
    bit              idle_en  = 1'b1;
    int              gap_odds = 4;
    bit              hold_req = 1'b0;
    int              cycles   = 0;

    alarm_offer_repeat_expire_top #(
        .TIME_BITS (TB_TIME_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Receiver: random stall bursts, and one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
                hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    function automatic stamp_t rnd_stamp();
        return {1'($urandom_range(0, 1)), 32'($urandom())};
    endfunction

    // Send one request and note it once accepted
    task automatic send_request(logic mode, stamp_t now_t, stamp_t occ, logic [1:0] code,
                                logic for_p, logic busy_f, logic acc);
        if (idle_en && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, acc, busy_f, for_p, code, occ, now_t};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(mode, now_t, occ, code, for_p, busy_f, acc);
    endtask

    task automatic arm(stamp_t occ);
        send_request(MODE_ARM, rnd_stamp(), occ, 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
    endtask

    task automatic service(stamp_t now_t, logic [1:0] code, logic for_p, logic busy_f,
                           logic acc);
        send_request(MODE_SERVICE, now_t, rnd_stamp(), code, for_p, busy_f, acc);
    endtask

    // Stop offering and let every expected result come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.due_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val, bit last);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, val);
        if (last) cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic [CFG_DATA_W-1:0] g, logic [CFG_DATA_W-1:0] r,
                              logic [CFG_DATA_W-1:0] rp, logic [CFG_DATA_W-1:0] b);
        drain();
        cfg_write(CFG_GRACE, g, 1'b0);
        cfg_write(CFG_RINGS, r, 1'b0);
        cfg_write(CFG_REPEAT, rp, 1'b0);
        cfg_write(CFG_BUSY, b, 1'b1);
    endtask

    // Random part: mostly arm-then-service runs around the moment, some noise
    task automatic run_random(int count);
        int              done;
        int              len;
        int              pick;
        stamp_t          moment_t;
        stamp_t          cur;
        longint unsigned g;
        longint unsigned rp;
        logic [1:0]      code;

        done = 0;
        while (done < count) begin
            if ($urandom_range(0, 99) < 15) begin
                send_request(1'($urandom_range(0, 1)), rnd_stamp(), rnd_stamp(),
                             2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                done++;
            end else begin
                case ($urandom_range(0, 3))
                    0: moment_t = rnd_stamp();
                    1: moment_t = stamp_t'($urandom_range(0, 100));
                    2: moment_t = '1 - stamp_t'($urandom_range(0, 100));
                    default: moment_t = stamp_t'($urandom());
                endcase
                arm(moment_t);
                done++;
                cur = moment_t - stamp_t'($urandom_range(0, 40));
                len = $urandom_range(1, 14);
                for (int i = 0; i < len; i++) begin
                    g  = sb.grace;
                    rp = sb.repeat_iv;
                    pick = $urandom_range(0, 9);
                    case (pick)
                        0, 1, 2, 3, 4, 5: cur = cur + stamp_t'($urandom_range(0, 32'(rp*2 + 2)));
                        6: cur = cur - stamp_t'($urandom_range(0, 32'(rp + 2)));
                        7: cur = cur + stamp_t'($urandom_range(0, 32'(g/4 + 1)));
                        8: cur = moment_t + stamp_t'(g) + stamp_t'($urandom_range(0, 2)) - 1;
                        default: ;
                    endcase
                    pick = $urandom_range(0, 19);
                    code = (pick < 2) ? ANS_START : (pick < 4) ? ANS_DISMISS :
                           (pick == 4) ? ANS_SPARE : ANS_NONE;
                    service(cur, code, 1'($urandom_range(0, 4) != 0),
                            1'($urandom_range(0, 3) == 0), 1'($urandom_range(0, 7) != 0));
                    done++;
                end
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset settings
        service(33'd0, ANS_NONE, 1'b0, 1'b0, 1'b1);           // nothing pending
        arm(33'd1000);
        service(33'd990, ANS_NONE, 1'b0, 1'b1, 1'b1);         // busy, early
        service(33'd995, ANS_START, 1'b1, 1'b0, 1'b1);        // answer before offer
        service(33'd1005, ANS_SPARE, 1'b1, 1'b0, 1'b1);       // spare code is no answer
        service(33'd990, ANS_NONE, 1'b0, 1'b0, 1'b1);         // before last ring
        service(33'd1100, ANS_DISMISS, 1'b0, 1'b0, 1'b1);     // answer for another one
        service(33'd1130, ANS_NONE, 1'b0, 1'b0, 1'b1);
        service(33'd1160, ANS_NONE, 1'b0, 1'b0, 1'b1);
        service(33'd1200, ANS_NONE, 1'b0, 1'b0, 1'b1);        // ring cap reached
        service(33'd1500, ANS_START, 1'b1, 1'b0, 1'b1);
        arm(33'd0);
        arm('1);                                              // replace while pending
        service('1, ANS_NONE, 1'b0, 1'b0, 1'b0);              // refused
        arm(33'd100);
        service(33'd1901, ANS_NONE, 1'b0, 1'b0, 1'b1);        // missed
        arm(33'd5000);
        service(33'd5000, ANS_NONE, 1'b0, 1'b0, 1'b1);
        service(33'd6801, ANS_NONE, 1'b0, 1'b0, 1'b1);        // expired
        arm(33'd8000);
        service(33'd7000, ANS_NONE, 1'b0, 1'b0, 1'b1);        // rung early
        service(33'd7030, ANS_DISMISS, 1'b1, 1'b0, 1'b1);
        arm(33'd0);
        service(33'd0, ANS_SPARE, 1'b1, 1'b1, 1'b1);
        service('1, ANS_NONE, 1'b1, 1'b0, 1'b1);              // far past grace

        // Lowest nonzero settings
        set_config(17'd1, 17'd1, 17'd1, 17'd1);
        run_random(170);

        // High settings, with a long receiver hold-off
        set_config(17'd86400, 17'd63, 17'd3600, 17'd3600);
        hold_req = 1'b1;
        gap_odds = 0;
        run_random(60);
        gap_odds = 4;
        run_random(110);

        // Zero registers, plus a write to an unused index
        set_config(17'd0, 17'd0, 17'd0, 17'd0);
        @(posedge aclk);
        cfg_write(8'hFF, 17'h1FFFF, 1'b1);
        run_random(150);

        // Every register bit set
        set_config(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        run_random(150);

        // Random settings
        set_config(17'($urandom_range(1, 3000)), 17'($urandom_range(1, 8)),
                   17'($urandom_range(1, 120)), 17'($urandom_range(1, 200)));
        gap_odds = 2;
        run_random(200);

        // Closing stretch at full rate
        set_config(17'($urandom_range(60, 600)), 17'($urandom_range(2, 6)),
                   17'($urandom_range(5, 40)), 17'($urandom_range(5, 60)));
        idle_en = 1'b0;
        run_random(180);

        drain();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.due_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/aore_pkg.sv
hdl/aore_cfg_regs.sv
hdl/aore_decide.sv
hdl/alarm_offer_repeat_expire_top.sv
test/tb_alarm_offer_repeat_expire_top.sv
